>>> hdl/mlmd_pkg.sv
// ----------------------------------------------------------------------------
// mlmd_pkg
// shared types, codes and constants of the magic/length message deframer
// ----------------------------------------------------------------------------
package mlmd_pkg;

    // header layout
    localparam int HEADER_BYTES = 10;
    localparam int IDX_W        = 4;

    typedef logic [IDX_W-1:0] t_hdr_idx;

    localparam t_hdr_idx IDX_MAGIC_0 = t_hdr_idx'(0);
    localparam t_hdr_idx IDX_MAGIC_3 = t_hdr_idx'(3);
    localparam t_hdr_idx IDX_ID_LO   = t_hdr_idx'(4);
    localparam t_hdr_idx IDX_ID_HI   = t_hdr_idx'(5);
    localparam t_hdr_idx IDX_LEN_0   = t_hdr_idx'(6);
    localparam t_hdr_idx IDX_LEN_1   = t_hdr_idx'(7);
    localparam t_hdr_idx IDX_LEN_2   = t_hdr_idx'(8);
    localparam t_hdr_idx IDX_LEN_3   = t_hdr_idx'(9);
    // any byte after the header
    localparam t_hdr_idx IDX_BODY    = t_hdr_idx'(HEADER_BYTES);

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PAYLOAD    = 2'd0;
    localparam t_kind KIND_BAD_MAGIC  = 2'd1;
    localparam t_kind KIND_BAD_LENGTH = 2'd2;

    // configuration registers
    localparam int APB_ADDR_W = 3;
    localparam logic REG_MAGIC_WORD = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;
    localparam logic [31:0] MAGIC_WORD_RESET = 32'h4642_4542;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd4096;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified item
    typedef struct packed {
        logic       restart;
        t_hdr_idx   idx;
        logic [7:0] data_byte;
    } t_entry;

    // queue status seen by the back part
    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_queue_stat;

endpackage

>>> hdl/mlmd_if.sv
// ----------------------------------------------------------------------------
// mlmd_if
// valid/ready channels of the deframer: byte input and result output
// ----------------------------------------------------------------------------
interface mlmd_in_if;
    import mlmd_pkg::*;

    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface mlmd_out_if;
    import mlmd_pkg::*;

    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [7:0]  payload_byte;
    logic [15:0] event_id;
    logic [31:0] message_length;
    logic        last;

    modport source (
        output valid, output kind, output payload_byte, output event_id,
        output message_length, output last, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input event_id,
        input message_length, input last, output ready
    );
endinterface

>>> hdl/mlmd_front.sv
// ----------------------------------------------------------------------------
// mlmd_front
// accepts input items and tags each byte with its header position
// ----------------------------------------------------------------------------
module mlmd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mlmd_in_if.sink         i_in,
    input  logic            i_queue_full,
    output logic            o_push,
    output mlmd_pkg::t_entry o_entry
);
    import mlmd_pkg::*;

    t_hdr_idx r_hdr_idx;
    t_hdr_idx n_hdr_idx;

    // take an item whenever the queue has room
    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    // classify: restart, or the byte's place in the header
    assign o_entry.restart   = i_in.func;
    assign o_entry.idx       = r_hdr_idx;
    assign o_entry.data_byte = i_in.data_byte;

    // header position, saturating once the header is complete
    always_comb begin
        n_hdr_idx = r_hdr_idx;
        if (o_push) begin
            if (i_in.func) begin
                n_hdr_idx = IDX_MAGIC_0;
            end else if (r_hdr_idx != IDX_BODY) begin
                n_hdr_idx = r_hdr_idx + t_hdr_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= IDX_MAGIC_0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
        end
    end

endmodule

>>> hdl/mlmd_queue.sv
// ----------------------------------------------------------------------------
// mlmd_queue
// short fifo of classified items between the front and back parts
// ----------------------------------------------------------------------------
module mlmd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mlmd_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output mlmd_pkg::t_queue_stat o_stat
);
    import mlmd_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/mlmd_back.sv
// ----------------------------------------------------------------------------
// mlmd_back
// session state machine: header checks, payload tagging, result register
// ----------------------------------------------------------------------------
module mlmd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mlmd_pkg::t_queue_stat i_stat,
    output logic                  o_pop,
    input  logic [31:0]           i_magic_word,
    input  logic [31:0]           i_max_length,
    mlmd_out_if.source            o_out
);
    import mlmd_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;

    logic [1:0]  r_phase,         n_phase;
    logic [31:0] r_magic_seen,    n_magic_seen;
    logic [15:0] r_event_id,      n_event_id;
    logic [31:0] r_held_length,   n_held_length;
    logic [31:0] r_payload_count, n_payload_count;

    logic        r_out_valid,     n_out_valid;
    t_kind       r_out_kind,      n_out_kind;
    logic [7:0]  r_out_byte,      n_out_byte;
    logic [15:0] r_out_event_id;
    logic [31:0] r_out_length;
    logic        r_out_last,      n_out_last;
    logic        w_emit;

    logic [31:0] w_next_count;
    logic        w_is_last;
    t_entry      w_head;

    assign w_head       = i_stat.head;
    assign o_pop        = !i_stat.empty && (!r_out_valid || o_out.ready);
    assign w_next_count = r_payload_count + 32'd1;
    assign w_is_last    = (w_next_count >= r_held_length);

    // session update for the popped item
    always_comb begin
        n_phase         = r_phase;
        n_magic_seen    = r_magic_seen;
        n_event_id      = r_event_id;
        n_held_length   = r_held_length;
        n_payload_count = r_payload_count;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_kind      = r_out_kind;
        n_out_byte      = r_out_byte;
        n_out_last      = r_out_last;
        w_emit          = 1'b0;

        if (o_pop) begin
            if (w_head.restart) begin
                n_phase         = PH_HEADER;
                n_magic_seen    = '0;
                n_event_id      = '0;
                n_held_length   = '0;
                n_payload_count = '0;
            end else begin
                unique case (w_head.idx) inside
                    [IDX_MAGIC_0:IDX_MAGIC_3]: n_magic_seen = {r_magic_seen[23:0],
                                                               w_head.data_byte};
                    IDX_ID_LO: n_event_id       = {8'd0, w_head.data_byte};
                    IDX_ID_HI: n_event_id[15:8] = w_head.data_byte;
                    IDX_LEN_0: n_held_length    = {24'd0, w_head.data_byte};
                    IDX_LEN_1: n_held_length[15:8]  = w_head.data_byte;
                    IDX_LEN_2: n_held_length[23:16] = w_head.data_byte;
                    IDX_LEN_3: n_held_length[31:24] = w_head.data_byte;
                    default: begin
                        // body byte: passes only in the payload phase
                        if (r_phase == PH_PAYLOAD) begin
                            w_emit     = 1'b1;
                            n_out_kind = KIND_PAYLOAD;
                            n_out_byte = w_head.data_byte;
                            n_out_last = w_is_last;
                            if (w_is_last) begin
                                n_phase         = PH_CLOSED;
                                n_payload_count = '0;
                            end else begin
                                n_payload_count = w_next_count;
                            end
                        end
                    end
                endcase

                // header complete: check magic, then length
                if (w_head.idx == IDX_LEN_3) begin
                    if (r_magic_seen != i_magic_word) begin
                        w_emit     = 1'b1;
                        n_out_kind = KIND_BAD_MAGIC;
                        n_out_byte = '0;
                        n_out_last = 1'b0;
                        n_phase    = PH_CLOSED;
                    end else if (n_held_length == '0 || n_held_length > i_max_length) begin
                        w_emit     = 1'b1;
                        n_out_kind = KIND_BAD_LENGTH;
                        n_out_byte = '0;
                        n_out_last = 1'b0;
                        n_phase    = PH_CLOSED;
                    end else begin
                        n_phase         = PH_PAYLOAD;
                        n_payload_count = '0;
                    end
                end
            end
            if (w_emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEADER;
            r_magic_seen    <= '0;
            r_event_id      <= '0;
            r_held_length   <= '0;
            r_payload_count <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_magic_seen    <= n_magic_seen;
            r_event_id      <= n_event_id;
            r_held_length   <= n_held_length;
            r_payload_count <= n_payload_count;
            r_out_valid     <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind     <= n_out_kind;
            r_out_byte     <= n_out_byte;
            r_out_event_id <= n_event_id;
            r_out_length   <= n_held_length;
            r_out_last     <= n_out_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out_kind;
    assign o_out.payload_byte   = r_out_byte;
    assign o_out.event_id       = r_out_event_id;
    assign o_out.message_length = r_out_length;
    assign o_out.last           = r_out_last;

    // an error result always leaves the session closed
    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_PAYLOAD) |-> (r_phase == PH_CLOSED))
        else $error("error result pending while session not closed");

    // the final payload byte closes the session
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD && r_out_last) |-> (r_phase == PH_CLOSED))
        else $error("last payload item pending while session not closed");

    // a non-final payload byte keeps the session in payload phase
    a_mid_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD && !r_out_last)
            |-> (r_phase == PH_PAYLOAD && r_payload_count < r_held_length))
        else $error("payload item pending outside payload phase");

endmodule

>>> hdl/magic_length_message_deframer_core.sv
// ----------------------------------------------------------------------------
// magic_length_message_deframer_core
// byte stream deframer: magic / event id / length header, then payload bytes
// ----------------------------------------------------------------------------
// Accepts one item per clock cycle while the queue has room; each item is
// registered in the queue, then any result it yields in the output register (input
// classifier, two-entry queue, session state machine with result register).
// Back-pressure on the output stalls only the session logic; the input keeps
// taking items until the queue is full. The user must write magic_word (0x0) and
// max_length (0x4) over the APB-style port only while the block is idle; the block itself does not enforce this.
module magic_length_message_deframer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mlmd_in_if.sink                         i_in,
    mlmd_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mlmd_pkg::*;

    logic [31:0] r_magic_word;
    logic [31:0] r_max_length;
    logic        w_cfg_wr;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    t_entry      w_entry;
    t_queue_stat w_stat;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= MAGIC_WORD_RESET;
            r_max_length <= MAX_LENGTH_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_MAGIC_WORD) begin
                r_magic_word <= pwdata;
            end else begin
                r_max_length <= pwdata;
            end
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[2])
            REG_MAGIC_WORD: prdata = r_magic_word;
            REG_MAX_LENGTH: prdata = r_max_length;
            default:        prdata = '0;
        endcase
    end

    // front: accept and classify
    mlmd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    // queue between front and back
    mlmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_stat  (w_stat)
    );

    // back: session logic and result register
    mlmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stat       (w_stat),
        .o_pop        (w_pop),
        .i_magic_word (r_magic_word),
        .i_max_length (r_max_length),
        .o_out        (o_out)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the magic/length message deframer: framed byte
// traffic with random bursts and output stalls, checked against a cycle-free
// model of the header/payload session
// ----------------------------------------------------------------------------
module tb;
    import mlmd_pkg::*;

    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;
    localparam int   DRAIN_CYCLES = 12;
    localparam int   IDLE_GUARD   = 20000;

    typedef enum logic [1:0] {
        SESS_HEADER  = 2'd0,
        SESS_PAYLOAD = 2'd1,
        SESS_CLOSED  = 2'd2
    } t_sess_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] event_id;
        logic [31:0] message_length;
        logic        last;
    } t_deframe_result;

    // session model plus queue of results still owed by the block
    class frame_checker;
        logic [31:0]     magic_word;
        logic [31:0]     max_length;
        t_sess_phase     phase;
        t_hdr_idx        hdr_count;
        logic [31:0]     magic_acc;
        logic [15:0]     id_acc;
        logic [31:0]     len_acc;
        logic [31:0]     pay_count;
        t_deframe_result awaited_results[$];
        int              errors;

        function new();
            magic_word    = MAGIC_WORD_RESET;
            max_length    = MAX_LENGTH_RESET;
            errors        = 0;
            clear_session();
        endfunction

        function void clear_session();
            phase     = SESS_HEADER;
            hdr_count = '0;
            magic_acc = '0;
            id_acc    = '0;
            len_acc   = '0;
            pay_count = '0;
        endfunction

        function void write_register(logic idx, logic [31:0] value);
            if (idx == REG_MAGIC_WORD) begin
                magic_word = value;
            end else begin
                max_length = value;
            end
        endfunction

        function void emit(t_kind kind, logic [7:0] data, logic last);
            t_deframe_result r;
            r.kind           = kind;
            r.payload_byte   = data;
            r.event_id       = id_acc;
            r.message_length = len_acc;
            r.last           = last;
            awaited_results.push_back(r);
        endfunction

        // advance the session by one accepted item
        function void absorb_byte(logic func, logic [7:0] data);
            t_hdr_idx    n;
            int          sh;
            logic [31:0] next_count;
            logic        is_last;
            if (func == FUNC_RESTART) begin
                clear_session();
                return;
            end
            case (phase)
                SESS_HEADER: begin
                    n = hdr_count;
                    // magic arrives msb first, id and length lsb first
                    if (n < IDX_ID_LO) begin
                        magic_acc = {magic_acc[23:0], data};
                    end else if (n == IDX_ID_LO) begin
                        id_acc = {8'h00, data};
                    end else if (n == IDX_ID_HI) begin
                        id_acc[15:8] = data;
                    end else if (n == IDX_LEN_0) begin
                        len_acc = {24'h0, data};
                    end else begin
                        sh      = 8 * (int'(n) - int'(IDX_LEN_0));
                        len_acc = len_acc | (32'(data) << sh);
                    end
                    n = n + 1'b1;
                    if (int'(n) < HEADER_BYTES) begin
                        hdr_count = n;
                        return;
                    end
                    hdr_count = IDX_BODY;
                    if (magic_acc != magic_word) begin
                        phase = SESS_CLOSED;
                        emit(KIND_BAD_MAGIC, 8'h00, 1'b0);
                    end else if (len_acc < 32'd1 || len_acc > max_length) begin
                        phase = SESS_CLOSED;
                        emit(KIND_BAD_LENGTH, 8'h00, 1'b0);
                    end else begin
                        phase     = SESS_PAYLOAD;
                        pay_count = '0;
                    end
                end
                SESS_PAYLOAD: begin
                    next_count = pay_count + 32'd1;
                    is_last    = (next_count >= len_acc);
                    emit(KIND_PAYLOAD, data, is_last);
                    if (is_last) begin
                        phase     = SESS_CLOSED;
                        pay_count = '0;
                    end else begin
                        pay_count = next_count;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_deframe_result got);
            t_deframe_result want;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d byte %02h id %04h len %0d",
                                 got.kind, got.payload_byte, got.event_id,
                                 got.message_length));
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.payload_byte !== want.payload_byte)
                report($sformatf("payload_byte %02h, want %02h",
                                 got.payload_byte, want.payload_byte));
            if (got.event_id !== want.event_id)
                report($sformatf("event_id %04h, want %04h", got.event_id, want.event_id));
            if (got.message_length !== want.message_length)
                report($sformatf("message_length %08h, want %08h",
                                 got.message_length, want.message_length));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    mlmd_in_if  in_ch ();
    mlmd_out_if out_ch ();

    magic_length_message_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_checker    sb;
    t_deframe_result seen_result;
    int              burst_left;
    int              frame_items;
    int              stall_mode;
    int              mode_left;
    int              stall_left;
    int              tick;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #2_000_000;
        $display("magic_length_message_deframer_core verification failed");
        $finish;
    end

    // result side: check accepted items, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_result.kind           = out_ch.kind;
            seen_result.payload_byte   = out_ch.payload_byte;
            seen_result.event_id       = out_ch.event_id;
            seen_result.message_length = out_ch.message_length;
            seen_result.last           = out_ch.last;
            sb.check_result(seen_result);
        end
        tick++;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 9) < 7);
            2: out_ch.ready <= (tick % 4 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 12);
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // offer one item, with a random gap at the start of each burst
    task automatic push_item(input logic func, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= func;
        in_ch.data_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.absorb_byte(func, data);
        burst_left--;
    endtask

    task automatic restart_session();
        push_item(FUNC_RESTART, 8'($urandom_range(0, 255)));
        frame_items++;
    endtask

    task automatic send_header(input logic [31:0] magic, input logic [15:0] id,
                               input logic [31:0] len);
        for (int i = 0; i < 4; i++) push_item(FUNC_DATA, magic[31-8*i -: 8]);
        push_item(FUNC_DATA, id[7:0]);
        push_item(FUNC_DATA, id[15:8]);
        for (int i = 0; i < 4; i++) push_item(FUNC_DATA, len[8*i +: 8]);
        frame_items += HEADER_BYTES;
    endtask

    task automatic send_bytes(input int count);
        repeat (count) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
        frame_items += count;
    endtask

    // a length the current limit accepts, kept short (with a zero limit, a short one it rejects)
    function automatic logic [31:0] good_length();
        if (sb.max_length == 32'd0)
            return $urandom_range(1, 16);
        if (sb.max_length <= 32'd40 && $urandom_range(0, 3) == 0)
            return sb.max_length;
        if (sb.max_length < 32'd24)
            return $urandom_range(1, sb.max_length);
        return $urandom_range(1, 24);
    endfunction

    // one session: restart, then a good, bad, cut short or noisy frame
    task automatic send_frame();
        logic [31:0] magic;
        logic [31:0] len;
        logic [31:0] r;
        logic [15:0] id;
        int          pick;
        int          cut;
        restart_session();
        magic = sb.magic_word;
        id    = 16'($urandom_range(0, 65535));
        pick  = $urandom_range(0, 99);
        if (pick < 60) begin
            len = good_length();
            send_header(magic, id, len);
            send_bytes(int'(len));
        end else if (pick < 70) begin
            // magic off by one bit
            magic = magic ^ (32'h1 << $urandom_range(0, 31));
            send_header(magic, id, good_length());
        end else if (pick < 80) begin
            r = $urandom;
            if (r > sb.max_length) begin
                len = r;
            end else if (sb.max_length != '1 && $urandom_range(0, 1) == 1) begin
                len = sb.max_length + 32'd1;
            end else begin
                len = '0;
            end
            send_header(magic, id, len);
        end else if (pick < 90) begin
            // cut off by the next restart, inside the header or the payload
            if ($urandom_range(0, 1) == 0) begin
                send_bytes($urandom_range(0, HEADER_BYTES - 1));
            end else begin
                if (sb.max_length == '1 && $urandom_range(0, 1) == 1) begin
                    len = '1;
                end else begin
                    len = good_length();
                end
                send_header(magic, id, len);
                cut = (len > 32'd9) ? 8 : int'(len) - 1;
                send_bytes($urandom_range(0, cut));
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                push_item(($urandom_range(0, 4) == 0) ? FUNC_RESTART : FUNC_DATA,
                          8'($urandom_range(0, 255)));
                frame_items++;
            end
        end
        // stray bytes after the frame
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_traffic(input int budget);
        frame_items = 0;
        while (frame_items < budget) send_frame();
    endtask

    // stop offering, collect everything owed, let the pipeline settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (sb.awaited_results.size() != 0 && guard < IDLE_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.awaited_results.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.awaited_results.size()));
            sb.awaited_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        sb              = new();
        burst_left      = 0;
        frame_items     = 0;
        stall_mode      = 0;
        mode_left       = 0;
        stall_left      = 0;
        tick            = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_DATA;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-byte message straight out of reset, discard when closed,
        // restart, bad magic with all-zero header, discard after error
        send_header(MAGIC_WORD_RESET, 16'hFFFF, 32'd1);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_DATA, 8'h00);
        push_item(FUNC_RESTART, 8'hAA);
        send_header(32'h0, 16'h0, 32'h0);
        push_item(FUNC_DATA, 8'h55);

        run_traffic(300);
        wait_idle();

        // zero magic, single-byte messages only
        apb_write(REG_MAGIC_WORD, 32'h0);
        apb_write(REG_MAX_LENGTH, 32'd1);
        run_traffic(180);
        wait_idle();

        // all ones: any nonzero length is accepted
        apb_write(REG_MAGIC_WORD, 32'hFFFF_FFFF);
        apb_write(REG_MAX_LENGTH, 32'hFFFF_FFFF);
        run_traffic(200);
        wait_idle();

        // zero limit rejects every length
        apb_write(REG_MAGIC_WORD, $urandom);
        apb_write(REG_MAX_LENGTH, 32'd0);
        run_traffic(120);
        wait_idle();

        // small random limit
        apb_write(REG_MAGIC_WORD, $urandom);
        apb_write(REG_MAX_LENGTH, $urandom_range(2, 40));
        run_traffic(300);
        wait_idle();

        if (sb.errors == 0) begin
            $display("magic_length_message_deframer_core verification clean");
        end else begin
            $display("magic_length_message_deframer_core verification failed");
        end
        $finish;
    end

endmodule
